// ===== hw/rtl/cartesian_to_polar_defines.svh =====
// ----------------------------------------------------------------------------
// Cartesian to polar: assertion macros
// Shared property templates for the checker of the conversion pipeline.
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_POLAR_DEFINES_SVH
`define CARTESIAN_TO_POLAR_DEFINES_SVH

// Implication in the same cycle, disabled while reset is held.
`define CTP_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Implication a fixed number of cycles later, disabled while reset is held.
`define CTP_ASSERT_DELAY(lbl, clk_s, rstn_s, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) \
    (ante) |-> ##(dly) (cons)) else $error(msg);

`endif

// ===== hw/rtl/ctp_pkg.sv =====
// ----------------------------------------------------------------------------
// Cartesian to polar: shared package
// Widths, fixed-point constants, quadrant codes and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package ctp_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS    = 8;

  localparam int TABLE_LEN = 24;
  localparam int NSTEPS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int STEP_W    = 5;

  localparam int GUARD  = 33 - COORD_WIDTH;
  localparam int ANG_FB = 16;
  localparam int DW     = 36;
  localparam int MW     = DW - 2;
  localparam int ZW     = 25;
  localparam int AW     = 26;

  localparam int RAD_W  = 24;
  localparam int ANG_W  = 17;
  localparam int QUAD_W = 3;

  localparam int GAIN_W     = 30;
  localparam int GAIN_SPLIT = 15;
  localparam int PPW        = MW + GAIN_SPLIT;
  localparam int PW         = MW + GAIN_W + 1;
  localparam logic [GAIN_W-1:0] INV_GAIN = 30'd652032874;
  localparam logic [GAIN_SPLIT-1:0] GAIN_HI = INV_GAIN[GAIN_W-1:GAIN_SPLIT];
  localparam logic [GAIN_SPLIT-1:0] GAIN_LO = INV_GAIN[GAIN_SPLIT-1:0];

  localparam int RSH = GUARD + GAIN_W - FRAC_BITS;
  localparam int ASH = ANG_FB - FRAC_BITS;
  localparam logic [PW-1:0] RAD_RND = PW'(1) << (RSH - 1);
  localparam logic [PW-1:0] RAD_MAX = PW'(24'hFFFFFF);
  localparam logic [AW-1:0] ANG_RND = (ASH > 0) ? (AW'(1) << (ASH - 1)) : '0;
  localparam logic [AW-1:0] FULL_ANG = AW'(360) << FRAC_BITS;

  localparam logic signed [ZW-1:0] Z90 = ZW'(90) << ANG_FB;
  localparam logic [AW-1:0] A90  = AW'(90) << ANG_FB;
  localparam logic [AW-1:0] A180 = AW'(180) << ANG_FB;
  localparam logic [AW-1:0] A270 = AW'(270) << ANG_FB;
  localparam logic [AW-1:0] A360 = AW'(360) << ANG_FB;

  localparam logic [QUAD_W-1:0] QUAD_ORIGIN = 3'd0;
  localparam logic [QUAD_W-1:0] QUAD_XAXIS  = 3'd1;
  localparam logic [QUAD_W-1:0] QUAD_YAXIS  = 3'd2;
  localparam logic [QUAD_W-1:0] QUAD_Q1     = 3'd3;
  localparam logic [QUAD_W-1:0] QUAD_Q2     = 3'd4;
  localparam logic [QUAD_W-1:0] QUAD_Q3     = 3'd5;
  localparam logic [QUAD_W-1:0] QUAD_Q4     = 3'd6;

  localparam int LATENCY = NSTEPS + 3;

  typedef struct packed {
    logic              vld;
    logic [QUAD_W-1:0] quad;
    logic              xneg;
    logic              yneg;
  } ctp_tag_t;

  function automatic logic signed [ZW-1:0] atan_q16(input logic [STEP_W-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 25'sd2949120;
      5'd1:    v = 25'sd1740967;
      5'd2:    v = 25'sd919879;
      5'd3:    v = 25'sd466945;
      5'd4:    v = 25'sd234379;
      5'd5:    v = 25'sd117304;
      5'd6:    v = 25'sd58666;
      5'd7:    v = 25'sd29335;
      5'd8:    v = 25'sd14668;
      5'd9:    v = 25'sd7334;
      5'd10:   v = 25'sd3667;
      5'd11:   v = 25'sd1833;
      5'd12:   v = 25'sd917;
      5'd13:   v = 25'sd458;
      5'd14:   v = 25'sd229;
      5'd15:   v = 25'sd115;
      5'd16:   v = 25'sd57;
      5'd17:   v = 25'sd29;
      5'd18:   v = 25'sd14;
      5'd19:   v = 25'sd7;
      5'd20:   v = 25'sd4;
      5'd21:   v = 25'sd2;
      5'd22:   v = 25'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ctp_front.sv =====
// ----------------------------------------------------------------------------
// Cartesian to polar: input stage
// Registers a point as guarded magnitudes and classifies its quadrant.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   accept,
  input  logic signed [ctp_pkg::COORD_WIDTH-1:0] x_coord,
  input  logic signed [ctp_pkg::COORD_WIDTH-1:0] y_coord,
  output ctp_pkg::ctp_tag_t                      tag_o,
  output logic signed [ctp_pkg::DW-1:0]          x_o,
  output logic signed [ctp_pkg::DW-1:0]          y_o
);
  import ctp_pkg::*;

  ctp_tag_t             tag_r, tag_nxt;
  logic signed [DW-1:0] x_r, x_nxt;
  logic signed [DW-1:0] y_r, y_nxt;
  logic [COORD_WIDTH:0] xmag, ymag;
  logic                 xneg, yneg, xzero, yzero;

  always_comb begin
    xneg  = x_coord[COORD_WIDTH-1];
    yneg  = y_coord[COORD_WIDTH-1];
    xzero = (x_coord == '0);
    yzero = (y_coord == '0);
    xmag  = xneg ? (COORD_WIDTH+1)'(-$signed({x_coord[COORD_WIDTH-1], x_coord}))
                 : (COORD_WIDTH+1)'({1'b0, x_coord});
    ymag  = yneg ? (COORD_WIDTH+1)'(-$signed({y_coord[COORD_WIDTH-1], y_coord}))
                 : (COORD_WIDTH+1)'({1'b0, y_coord});
    x_nxt = DW'(xmag) << GUARD;
    y_nxt = DW'(ymag) << GUARD;
    tag_nxt.vld  = accept;
    tag_nxt.xneg = xneg;
    tag_nxt.yneg = yneg;
    if (xzero && yzero) begin
      tag_nxt.quad = QUAD_ORIGIN;
    end else if (yzero) begin
      tag_nxt.quad = QUAD_XAXIS;
    end else if (xzero) begin
      tag_nxt.quad = QUAD_YAXIS;
    end else if (!xneg && !yneg) begin
      tag_nxt.quad = QUAD_Q1;
    end else if (xneg && !yneg) begin
      tag_nxt.quad = QUAD_Q2;
    end else if (xneg) begin
      tag_nxt.quad = QUAD_Q3;
    end else begin
      tag_nxt.quad = QUAD_Q4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  assign tag_o = tag_r;
  assign x_o   = x_r;
  assign y_o   = y_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ctp_cell.sv =====
// ----------------------------------------------------------------------------
// Cartesian to polar: vectoring cell
// One CORDIC rotation step towards the x-axis, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ctp_pkg::STEP_W-1:0]    step_idx,
  input  ctp_pkg::ctp_tag_t             tag_i,
  input  logic signed [ctp_pkg::DW-1:0] x_i,
  input  logic signed [ctp_pkg::DW-1:0] y_i,
  input  logic signed [ctp_pkg::ZW-1:0] z_i,
  output ctp_pkg::ctp_tag_t             tag_o,
  output logic signed [ctp_pkg::DW-1:0] x_o,
  output logic signed [ctp_pkg::DW-1:0] y_o,
  output logic signed [ctp_pkg::ZW-1:0] z_o
);
  import ctp_pkg::*;

  ctp_tag_t             tag_r;
  logic signed [DW-1:0] x_r, x_nxt;
  logic signed [DW-1:0] y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic signed [DW-1:0] xsh, ysh;
  logic signed [ZW-1:0] atan_v;

  always_comb begin
    xsh    = x_i >>> step_idx;
    ysh    = y_i >>> step_idx;
    atan_v = atan_q16(step_idx);
    if (!y_i[DW-1]) begin
      x_nxt = x_i + ysh;
      y_nxt = y_i - xsh;
      z_nxt = z_i + atan_v;
    end else begin
      x_nxt = x_i - ysh;
      y_nxt = y_i + xsh;
      z_nxt = z_i - atan_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_i;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign tag_o = tag_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ctp_back.sv =====
// ----------------------------------------------------------------------------
// Cartesian to polar: output stages
// Gain correction of the radius and quadrant mapping of the angle.
// ----------------------------------------------------------------------------
`default_nettype none

module ctp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctp_pkg::ctp_tag_t             tag_i,
  input  logic signed [ctp_pkg::DW-1:0] x_i,
  input  logic signed [ctp_pkg::ZW-1:0] z_i,
  output logic                          out_valid,
  output logic [ctp_pkg::RAD_W-1:0]     out_radius,
  output logic [ctp_pkg::ANG_W-1:0]     out_angle_deg,
  output logic [ctp_pkg::QUAD_W-1:0]    out_quadrant
);
  import ctp_pkg::*;

  ctp_tag_t             tag1_r;
  logic [PPW-1:0]       phi_r, phi_nxt;
  logic [PPW-1:0]       plo_r, plo_nxt;
  logic [ANG_W-1:0]     ang1_r, ang1_nxt;
  logic [MW-1:0]        xmag;
  logic signed [ZW-1:0] zc;
  logic [AW-1:0]        ang, ang_rnd;

  logic                 vld_r;
  logic [RAD_W-1:0]     rad_r, rad_nxt;
  logic [ANG_W-1:0]     ang_r;
  logic [QUAD_W-1:0]    quad_r;
  logic [PW-1:0]        psum, pshift;

  always_comb begin
    xmag    = x_i[DW-1] ? '0 : x_i[MW-1:0];
    phi_nxt = PPW'(xmag) * PPW'(GAIN_HI);
    plo_nxt = PPW'(xmag) * PPW'(GAIN_LO);

    if (z_i < 0) begin
      zc = '0;
    end else if (z_i > Z90) begin
      zc = Z90;
    end else begin
      zc = z_i;
    end

    case (tag_i.quad)
      QUAD_ORIGIN: ang = '0;
      QUAD_XAXIS:  ang = tag_i.xneg ? A180 : '0;
      QUAD_YAXIS:  ang = tag_i.yneg ? A270 : A90;
      QUAD_Q1:     ang = AW'(zc[ZW-2:0]);
      QUAD_Q2:     ang = A180 - AW'(zc[ZW-2:0]);
      QUAD_Q3:     ang = A180 + AW'(zc[ZW-2:0]);
      QUAD_Q4:     ang = A360 - AW'(zc[ZW-2:0]);
      default:     ang = '0;
    endcase

    ang_rnd = (ang + ANG_RND) >> ASH;
    if (ang_rnd >= FULL_ANG) begin
      ang_rnd = ang_rnd - FULL_ANG;
    end
    ang1_nxt = ang_rnd[ANG_W-1:0];
  end

  always_comb begin
    psum   = (PW'(phi_r) << GAIN_SPLIT) + PW'(plo_r) + RAD_RND;
    pshift = psum >> RSH;
    if (tag1_r.quad == QUAD_ORIGIN) begin
      rad_nxt = '0;
    end else if (pshift > RAD_MAX) begin
      rad_nxt = RAD_MAX[RAD_W-1:0];
    end else begin
      rad_nxt = pshift[RAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      tag1_r <= tag_i;
      vld_r  <= tag1_r.vld;
    end
    phi_r  <= phi_nxt;
    plo_r  <= plo_nxt;
    ang1_r <= ang1_nxt;
    rad_r  <= rad_nxt;
    ang_r  <= ang1_r;
    quad_r <= tag1_r.quad;
  end

  assign out_valid     = vld_r;
  assign out_radius    = rad_r;
  assign out_angle_deg = ang_r;
  assign out_quadrant  = quad_r;

endmodule

`default_nettype wire

// ===== hw/rtl/cartesian_to_polar.sv =====
// Path: an accepted start reaches the out_valid strobe through the input
// register, one cell per CORDIC step and two output stages.
// Throughput: one transaction every cycle; busy is never raised, the chain of
// cells is fully pipelined and each result is strobed for exactly one cycle.
// Reset: synchronous, active low; it clears the valid bits along the chain, so
// no strobe appears until a new transaction has passed through.
// ----------------------------------------------------------------------------
// Cartesian to polar: top level
// Converts a signed integer point into radius, angle in degrees and quadrant.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_to_polar (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [ctp_pkg::COORD_WIDTH-1:0] in_x_coord,
  input  logic signed [ctp_pkg::COORD_WIDTH-1:0] in_y_coord,
  output logic                                   out_valid,
  output logic [ctp_pkg::RAD_W-1:0]              out_radius,
  output logic [ctp_pkg::ANG_W-1:0]              out_angle_deg,
  output logic [ctp_pkg::QUAD_W-1:0]             out_quadrant
);
  import ctp_pkg::*;

  ctp_tag_t             tag_s [0:NSTEPS];
  logic signed [DW-1:0] x_s   [0:NSTEPS];
  logic signed [DW-1:0] y_s   [0:NSTEPS];
  logic signed [ZW-1:0] z_s   [0:NSTEPS];

  assign busy   = 1'b0;
  assign z_s[0] = '0;

  ctp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (start && !busy),
    .x_coord (in_x_coord),
    .y_coord (in_y_coord),
    .tag_o   (tag_s[0]),
    .x_o     (x_s[0]),
    .y_o     (y_s[0])
  );

  for (genvar i = 0; i < NSTEPS; i++) begin : g_cell
    ctp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .step_idx (STEP_W'(i)),
      .tag_i    (tag_s[i]),
      .x_i      (x_s[i]),
      .y_i      (y_s[i]),
      .z_i      (z_s[i]),
      .tag_o    (tag_s[i+1]),
      .x_o      (x_s[i+1]),
      .y_o      (y_s[i+1]),
      .z_o      (z_s[i+1])
    );
  end

  ctp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .tag_i         (tag_s[NSTEPS]),
    .x_i           (x_s[NSTEPS]),
    .z_i           (z_s[NSTEPS]),
    .out_valid     (out_valid),
    .out_radius    (out_radius),
    .out_angle_deg (out_angle_deg),
    .out_quadrant  (out_quadrant)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/ctp_checker.sv =====
// ----------------------------------------------------------------------------
// Cartesian to polar: port checker
// Timing and range properties seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cartesian_to_polar_defines.svh"

module ctp_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   start,
  input logic                                   busy,
  input logic signed [ctp_pkg::COORD_WIDTH-1:0] in_x_coord,
  input logic signed [ctp_pkg::COORD_WIDTH-1:0] in_y_coord,
  input logic                                   out_valid,
  input logic [ctp_pkg::RAD_W-1:0]              out_radius,
  input logic [ctp_pkg::ANG_W-1:0]              out_angle_deg,
  input logic [ctp_pkg::QUAD_W-1:0]             out_quadrant
);
  import ctp_pkg::*;

  logic accept;
  assign accept = start && !busy;

  `CTP_ASSERT_DELAY(a_result_follows, clk, rst_n, accept, LATENCY, out_valid, "transaction lost")
  `CTP_ASSERT_IMPL(a_no_spurious, clk, rst_n, out_valid, $past(accept, LATENCY), "result without transaction")
  `CTP_ASSERT_DELAY(a_origin, clk, rst_n, accept && in_x_coord == '0 && in_y_coord == '0, LATENCY, out_quadrant == QUAD_ORIGIN && out_radius == '0 && out_angle_deg == '0, "origin result wrong")
  `CTP_ASSERT_IMPL(a_ranges, clk, rst_n, out_valid, out_angle_deg < ANG_W'(FULL_ANG) && out_quadrant <= QUAD_Q4, "result out of range")

endmodule

bind cartesian_to_polar ctp_checker u_ctp_checker (.*);

`default_nettype wire
